@@ hw/rtl/cvpm_pkg.sv @@
// ----------------------------------------------------------------------------
// cvpm_pkg: shared types and constants of the cell voltage protection monitor
// Holds field widths, register indexes, the configuration record and its
// reset values, and the statistics constants used by several modules.
// ----------------------------------------------------------------------------
package cvpm_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned CELL_W   = 4;
    localparam int unsigned TOTAL_W  = 20;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned OFFSET_W = 10;
    localparam int unsigned DELAY_W  = 16;

    // Configuration port geometry.
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Statistics constants.
    localparam logic [CODE_W-1:0]  MIN_START = 16'd60000;
    localparam logic [CODE_W-1:0]  CODE_MAX  = 16'hFFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;
    localparam logic [COUNT_W-1:0] LIVE_MAX  = 4'd15;

    // Command codes of an input item.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Register indexes (word address bits of paddr).
    typedef enum logic [2:0] {
        REG_HARD_OVER   = 3'd0,
        REG_SOFT_OVER   = 3'd1,
        REG_HARD_UNDER  = 3'd2,
        REG_SOFT_UNDER  = 3'd3,
        REG_OVER_DELAY  = 3'd4,
        REG_UNDER_DELAY = 3'd5,
        REG_CELLS       = 3'd6,
        REG_OFFSET      = 3'd7
    } reg_idx_t;

    // Configuration record handed from the register file to the datapath.
    typedef struct packed {
        logic [CODE_W-1:0]   hard_over_limit;
        logic [CODE_W-1:0]   soft_over_limit;
        logic [CODE_W-1:0]   hard_under_limit;
        logic [CODE_W-1:0]   soft_under_limit;
        logic [DELAY_W-1:0]  over_delay_ticks;
        logic [DELAY_W-1:0]  under_delay_ticks;
        logic [COUNT_W-1:0]  cells_in_use;
        logic [OFFSET_W-1:0] first_cell_offset;
    } cfg_t;

    // Reset values of the configuration registers.
    localparam cfg_t CFG_RESET = '{
        hard_over_limit:   16'd42500,
        soft_over_limit:   16'd42000,
        hard_under_limit:  16'd25000,
        soft_under_limit:  16'd30000,
        over_delay_ticks:  16'd1000,
        under_delay_ticks: 16'd1000,
        cells_in_use:      4'd12,
        first_cell_offset: 10'd430
    };

endpackage

@@ hw/rtl/cvpm_regs.sv @@
// ----------------------------------------------------------------------------
// cvpm_regs: configuration register file
// APB-style slave holding the limits, delays, cell count and cell zero
// offset. Writes land on the access phase; reads return the stored value.
// ----------------------------------------------------------------------------
module cvpm_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cvpm_pkg::ADDR_W-1:0]   paddr,
    input  logic [cvpm_pkg::DATA_W-1:0]   pwdata,
    output logic [cvpm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output cvpm_pkg::cfg_t                cfg
);

    cvpm_pkg::cfg_t     cfg_reg;
    cvpm_pkg::reg_idx_t reg_sel;
    logic               wr_en;

    assign reg_sel = cvpm_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register writes, one field per word address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cvpm_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                cvpm_pkg::REG_HARD_OVER:   cfg_reg.hard_over_limit   <= pwdata[15:0];
                cvpm_pkg::REG_SOFT_OVER:   cfg_reg.soft_over_limit   <= pwdata[15:0];
                cvpm_pkg::REG_HARD_UNDER:  cfg_reg.hard_under_limit  <= pwdata[15:0];
                cvpm_pkg::REG_SOFT_UNDER:  cfg_reg.soft_under_limit  <= pwdata[15:0];
                cvpm_pkg::REG_OVER_DELAY:  cfg_reg.over_delay_ticks  <= pwdata[15:0];
                cvpm_pkg::REG_UNDER_DELAY: cfg_reg.under_delay_ticks <= pwdata[15:0];
                cvpm_pkg::REG_CELLS:       cfg_reg.cells_in_use      <= pwdata[3:0];
                cvpm_pkg::REG_OFFSET:      cfg_reg.first_cell_offset <= pwdata[9:0];
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (reg_sel)
            cvpm_pkg::REG_HARD_OVER:   prdata = 32'(cfg_reg.hard_over_limit);
            cvpm_pkg::REG_SOFT_OVER:   prdata = 32'(cfg_reg.soft_over_limit);
            cvpm_pkg::REG_HARD_UNDER:  prdata = 32'(cfg_reg.hard_under_limit);
            cvpm_pkg::REG_SOFT_UNDER:  prdata = 32'(cfg_reg.soft_under_limit);
            cvpm_pkg::REG_OVER_DELAY:  prdata = 32'(cfg_reg.over_delay_ticks);
            cvpm_pkg::REG_UNDER_DELAY: prdata = 32'(cfg_reg.under_delay_ticks);
            cvpm_pkg::REG_CELLS:       prdata = 32'(cfg_reg.cells_in_use);
            cvpm_pkg::REG_OFFSET:      prdata = 32'(cfg_reg.first_cell_offset);
        endcase
    end

endmodule

@@ hw/rtl/cvpm_cell_mem.sv @@
// ----------------------------------------------------------------------------
// cvpm_cell_mem: per-cell state memory
// Synchronous single-read, single-write memory with registered read data.
// A valid bit per entry makes an entry that was never written read as zero.
// ----------------------------------------------------------------------------
module cvpm_cell_mem #(
    parameter int unsigned DEPTH  = 12,
    parameter int unsigned WIDTH  = 68,
    parameter int unsigned ADDR_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg;
    logic             data_valid_reg;

    // Storage array and read data register.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    // Entry valid bits and the valid flag of the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            data_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                data_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An entry never written reads as its reset value of zero.
    assign rd_data = data_valid_reg ? data_reg : '0;

endmodule

@@ hw/rtl/cvpm_fault_update.sv @@
// ----------------------------------------------------------------------------
// cvpm_fault_update: fault qualification of one limit pair
// Decides the new fault, pending mark and start time of one cell for either
// the overvoltage or the undervoltage side from the limit compare results.
// ----------------------------------------------------------------------------
module cvpm_fault_update #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                         open_wire,
    input  logic                         hard_hit,
    input  logic                         soft_hit,
    input  logic                         fault_in,
    input  logic                         pending_in,
    input  logic [TIME_BITS-1:0]         start_in,
    input  logic [TIME_BITS-1:0]         now,
    input  logic [cvpm_pkg::DELAY_W-1:0] delay,
    output logic                         fault_out,
    output logic                         pending_out,
    output logic [TIME_BITS-1:0]         start_out
);

    logic [TIME_BITS-1:0] elapsed;
    logic                 expired;

    // Elapsed time wraps with the time counter.
    assign elapsed = now - start_in;
    assign expired = elapsed > TIME_BITS'(delay);

    // Open cells only lose their fault; hard hits fault at once; the soft
    // band starts or checks the qualification timer.
    always_comb
    begin
        fault_out   = fault_in;
        pending_out = pending_in;
        start_out   = start_in;
        priority if (open_wire)
        begin
            fault_out = 1'b0;
        end
        else if (hard_hit)
        begin
            fault_out = 1'b1;
        end
        else if (soft_hit)
        begin
            if (!pending_in)
            begin
                pending_out = 1'b1;
                start_out   = now;
            end
            else if (expired)
            begin
                pending_out = 1'b0;
                fault_out   = 1'b1;
            end
        end
        else
        begin
            pending_out = 1'b0;
            fault_out   = 1'b0;
        end
    end

endmodule

@@ hw/rtl/cvpm_divider.sv @@
// ----------------------------------------------------------------------------
// cvpm_divider: iterative average divider
// Restoring division of the scan total by the live count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module cvpm_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cvpm_pkg::TOTAL_W-1:0] dividend,
    input  logic [cvpm_pkg::COUNT_W-1:0] divisor,
    output logic                         busy,
    output logic [cvpm_pkg::TOTAL_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(cvpm_pkg::TOTAL_W + 1);

    logic                         busy_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [cvpm_pkg::TOTAL_W-1:0] quot_reg;
    logic [cvpm_pkg::COUNT_W-1:0] rem_reg;
    logic [cvpm_pkg::COUNT_W-1:0] div_reg;
    logic [cvpm_pkg::COUNT_W:0]   trial;
    logic                         fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign trial = {rem_reg, quot_reg[cvpm_pkg::TOTAL_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    // Control: counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(cvpm_pkg::TOTAL_W);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[cvpm_pkg::TOTAL_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= cvpm_pkg::COUNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_reg <= trial[cvpm_pkg::COUNT_W-1:0];
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

@@ hw/rtl/cell_voltage_protection_monitor.sv @@
// ----------------------------------------------------------------------------
// cell_voltage_protection_monitor: battery cell over/undervoltage monitor
//
// Input items carry either a time tick (cmd high) or one cell sample with
// its index, 100 uV code and open-wire flag. Each sample whose index lies
// below the effective cell count yields one result item with the cell's
// fault flags; the sample of the last configured cell also carries the
// scan statistics (max, min, total, average, live count, wrong-count flag).
// Ticks and out-of-range samples give no result.
// Sequence: a tick or an ignored sample is accepted and done while idle. A
// sample is accepted with the state memory read, its cell entry is then
// read, modified and written back, and the output register is loaded.
// The last cell of a scan waits for the one-bit-per-cycle divider before
// loading. One item is in work at a time; the input is stalled while it is.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and finishes once the register has been taken.
// Reset clears all per-cell state (valid bits of the cell memory), the time
// counter and the statistics, and loads the register reset values. The
// configuration port is APB-style with pready always high.
// ----------------------------------------------------------------------------
module cell_voltage_protection_monitor #(
    parameter int unsigned MAX_CELLS = 12,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cvpm_pkg::ADDR_W-1:0]   paddr,
    input  logic [cvpm_pkg::DATA_W-1:0]   pwdata,
    output logic [cvpm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [cvpm_pkg::CELL_W-1:0]   cell_index,
    input  logic [cvpm_pkg::CODE_W-1:0]   cell_code,
    input  logic                          open_wire,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cvpm_pkg::CELL_W-1:0]   sample_index,
    output logic                          over_voltage,
    output logic                          under_voltage,
    output logic                          scan_done,
    output logic [cvpm_pkg::CODE_W-1:0]   max_code,
    output logic [cvpm_pkg::CELL_W-1:0]   max_cell,
    output logic [cvpm_pkg::CODE_W-1:0]   min_code,
    output logic [cvpm_pkg::CELL_W-1:0]   min_cell,
    output logic [cvpm_pkg::CODE_W-1:0]   average_code,
    output logic [cvpm_pkg::TOTAL_W-1:0]  total_code,
    output logic [cvpm_pkg::COUNT_W-1:0]  live_count,
    output logic                          count_wrong
);

    localparam int unsigned MEM_AW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int unsigned ENTRY_W = 2 * TIME_BITS + 4;
    localparam logic [4:0]  MAX_CELLS_V = 5'(MAX_CELLS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_EMIT
    } state_t;

    cvpm_pkg::cfg_t cfg;

    state_t state_reg, state_next;

    // Time and latched sample.
    logic [TIME_BITS-1:0]         time_reg, time_next;
    logic [cvpm_pkg::CELL_W-1:0]  idx_reg, idx_next;
    logic [cvpm_pkg::CODE_W-1:0]  code_reg, code_next;
    logic                         open_reg, open_next;

    // Scan statistics.
    logic [cvpm_pkg::CODE_W-1:0]  max_reg, max_next;
    logic [cvpm_pkg::CELL_W-1:0]  max_cell_reg, max_cell_next;
    logic [cvpm_pkg::CODE_W-1:0]  min_reg, min_next;
    logic [cvpm_pkg::CELL_W-1:0]  min_cell_reg, min_cell_next;
    logic [cvpm_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [cvpm_pkg::COUNT_W-1:0] live_reg, live_next;

    // Per-item result flags.
    logic over_res_reg, over_res_next;
    logic under_res_reg, under_res_next;
    logic last_reg, last_next;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic [cvpm_pkg::CELL_W-1:0]  o_index_reg, o_index_next;
    logic                         o_over_reg, o_over_next;
    logic                         o_under_reg, o_under_next;
    logic                         o_done_reg, o_done_next;
    logic [cvpm_pkg::CODE_W-1:0]  o_max_reg, o_max_next;
    logic [cvpm_pkg::CELL_W-1:0]  o_max_cell_reg, o_max_cell_next;
    logic [cvpm_pkg::CODE_W-1:0]  o_min_reg, o_min_next;
    logic [cvpm_pkg::CELL_W-1:0]  o_min_cell_reg, o_min_cell_next;
    logic [cvpm_pkg::CODE_W-1:0]  o_avg_reg, o_avg_next;
    logic [cvpm_pkg::TOTAL_W-1:0] o_total_reg, o_total_next;
    logic [cvpm_pkg::COUNT_W-1:0] o_live_reg, o_live_next;
    logic                         o_wrong_reg, o_wrong_next;

    // Cell memory signals.
    logic                 mem_rd_en;
    logic [MEM_AW-1:0]    mem_rd_addr;
    logic [ENTRY_W-1:0]   mem_rd_data;
    logic                 mem_wr_en;
    logic [ENTRY_W-1:0]   mem_wr_data;

    // Unpacked fields of the cell entry.
    logic [TIME_BITS-1:0] over_start_q, under_start_q;
    logic                 over_pend_q, under_pend_q, over_fault_q, under_fault_q;
    logic [TIME_BITS-1:0] over_start_d, under_start_d;
    logic                 over_pend_d, under_pend_d, over_fault_d, under_fault_d;

    // Divider signals.
    logic                         div_start;
    logic                         div_busy;
    logic [cvpm_pkg::TOTAL_W-1:0] div_quot;

    // Miscellaneous combinational values.
    logic [cvpm_pkg::COUNT_W-1:0]  n_eff;
    logic                          in_fire;
    logic                          idx_ok;
    logic [cvpm_pkg::CODE_W:0]     offset_sum;
    logic [cvpm_pkg::CODE_W-1:0]   adj_code;
    logic                          first_cell;
    logic [cvpm_pkg::CODE_W-1:0]   base_max, base_min;
    logic [cvpm_pkg::CELL_W-1:0]   base_max_cell, base_min_cell;
    logic [cvpm_pkg::TOTAL_W-1:0]  base_total;
    logic [cvpm_pkg::COUNT_W-1:0]  base_live;
    logic [cvpm_pkg::TOTAL_W:0]    total_sum;
    logic                          is_last;
    logic                          slot_free;
    logic [cvpm_pkg::CODE_W-1:0]   avg_value;

    cvpm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cvpm_cell_mem #(
        .DEPTH  (MAX_CELLS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (MEM_AW)
    ) u_cell_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (idx_reg[MEM_AW-1:0]),
        .wr_data (mem_wr_data)
    );

    cvpm_fault_update #(
        .TIME_BITS (TIME_BITS)
    ) u_over (
        .open_wire   (open_reg),
        .hard_hit    (code_reg >= cfg.hard_over_limit),
        .soft_hit    (code_reg >= cfg.soft_over_limit),
        .fault_in    (over_fault_q),
        .pending_in  (over_pend_q),
        .start_in    (over_start_q),
        .now         (time_reg),
        .delay       (cfg.over_delay_ticks),
        .fault_out   (over_fault_d),
        .pending_out (over_pend_d),
        .start_out   (over_start_d)
    );

    cvpm_fault_update #(
        .TIME_BITS (TIME_BITS)
    ) u_under (
        .open_wire   (open_reg),
        .hard_hit    (code_reg <= cfg.hard_under_limit),
        .soft_hit    (code_reg <= cfg.soft_under_limit),
        .fault_in    (under_fault_q),
        .pending_in  (under_pend_q),
        .start_in    (under_start_q),
        .now         (time_reg),
        .delay       (cfg.under_delay_ticks),
        .fault_out   (under_fault_d),
        .pending_out (under_pend_d),
        .start_out   (under_start_d)
    );

    cvpm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (live_next),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Effective cell count: zero acts as one, the count is capped at the depth.
    always_comb
    begin
        n_eff = cfg.cells_in_use;
        if (cfg.cells_in_use == '0)
        begin
            n_eff = cvpm_pkg::COUNT_W'(1);
        end
        else if ({1'b0, cfg.cells_in_use} > MAX_CELLS_V)
        begin
            n_eff = MAX_CELLS_V[cvpm_pkg::COUNT_W-1:0];
        end
    end

    // Input handshake and the cell zero calibration offset.
    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign idx_ok     = cell_index < n_eff;
    assign offset_sum = {1'b0, cell_code} + (cvpm_pkg::CODE_W + 1)'(cfg.first_cell_offset);
    assign adj_code   = offset_sum[cvpm_pkg::CODE_W] ? cvpm_pkg::CODE_MAX
                                                     : offset_sum[cvpm_pkg::CODE_W-1:0];

    // The cell entry is read as the sample is accepted.
    assign mem_rd_en   = in_fire && (cmd == cvpm_pkg::CMD_SAMPLE) && idx_ok;
    assign mem_rd_addr = cell_index[MEM_AW-1:0];

    // Entry layout: over start, under start, then the four flags.
    assign over_start_q  = mem_rd_data[ENTRY_W-1 -: TIME_BITS];
    assign under_start_q = mem_rd_data[ENTRY_W-TIME_BITS-1 -: TIME_BITS];
    assign over_pend_q   = mem_rd_data[3];
    assign under_pend_q  = mem_rd_data[2];
    assign over_fault_q  = mem_rd_data[1];
    assign under_fault_q = mem_rd_data[0];
    assign mem_wr_data   = {over_start_d, under_start_d,
                            over_pend_d, under_pend_d, over_fault_d, under_fault_d};
    assign mem_wr_en     = (state_reg == S_UPDATE);

    // Statistics of the scan, restarted by the cell zero sample.
    assign first_cell    = (idx_reg == '0);
    assign base_max      = first_cell ? '0 : max_reg;
    assign base_max_cell = first_cell ? '0 : max_cell_reg;
    assign base_min      = first_cell ? cvpm_pkg::MIN_START : min_reg;
    assign base_min_cell = first_cell ? '0 : min_cell_reg;
    assign base_total    = first_cell ? '0 : total_reg;
    assign base_live     = first_cell ? '0 : live_reg;
    assign total_sum     = {1'b0, base_total} + (cvpm_pkg::TOTAL_W + 1)'(code_reg);
    assign is_last       = (idx_reg == n_eff - 1'b1);
    assign div_start     = (state_reg == S_UPDATE) && is_last;

    // Average from the finished division, saturated to the code range.
    always_comb
    begin
        if (live_reg == '0)
        begin
            avg_value = '0;
        end
        else if (div_quot > cvpm_pkg::TOTAL_W'(cvpm_pkg::CODE_MAX))
        begin
            avg_value = cvpm_pkg::CODE_MAX;
        end
        else
        begin
            avg_value = div_quot[cvpm_pkg::CODE_W-1:0];
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;

    // Sequencer, statistics and output register next values.
    always_comb
    begin
        state_next      = state_reg;
        time_next       = time_reg;
        idx_next        = idx_reg;
        code_next       = code_reg;
        open_next       = open_reg;
        max_next        = max_reg;
        max_cell_next   = max_cell_reg;
        min_next        = min_reg;
        min_cell_next   = min_cell_reg;
        total_next      = total_reg;
        live_next       = live_reg;
        over_res_next   = over_res_reg;
        under_res_next  = under_res_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        o_index_next    = o_index_reg;
        o_over_next     = o_over_reg;
        o_under_next    = o_under_reg;
        o_done_next     = o_done_reg;
        o_max_next      = o_max_reg;
        o_max_cell_next = o_max_cell_reg;
        o_min_next      = o_min_reg;
        o_min_cell_next = o_min_cell_reg;
        o_avg_next      = o_avg_reg;
        o_total_next    = o_total_reg;
        o_live_next     = o_live_reg;
        o_wrong_next    = o_wrong_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd == cvpm_pkg::CMD_TICK)
                    begin
                        time_next = time_reg + 1'b1;
                    end
                    else if (idx_ok)
                    begin
                        idx_next   = cell_index;
                        code_next  = (cell_index == '0) ? adj_code : cell_code;
                        open_next  = open_wire;
                        state_next = S_UPDATE;
                    end
                end
            end

            S_UPDATE:
            begin
                max_next      = base_max;
                max_cell_next = base_max_cell;
                min_next      = base_min;
                min_cell_next = base_min_cell;
                total_next    = base_total;
                live_next     = base_live;
                if (!open_reg)
                begin
                    if (code_reg > base_max)
                    begin
                        max_next      = code_reg;
                        max_cell_next = idx_reg;
                    end
                    if (code_reg < base_min)
                    begin
                        min_next      = code_reg;
                        min_cell_next = idx_reg;
                    end
                    total_next = total_sum[cvpm_pkg::TOTAL_W] ? cvpm_pkg::TOTAL_MAX
                                                              : total_sum[cvpm_pkg::TOTAL_W-1:0];
                    if (base_live != cvpm_pkg::LIVE_MAX)
                    begin
                        live_next = base_live + 1'b1;
                    end
                end
                over_res_next  = over_fault_d;
                under_res_next = under_fault_d;
                last_next      = is_last;
                state_next     = is_last ? S_DIVIDE : S_EMIT;
            end

            S_DIVIDE:
            begin
                if (!div_busy)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    o_index_next    = idx_reg;
                    o_over_next     = over_res_reg;
                    o_under_next    = under_res_reg;
                    o_done_next     = last_reg;
                    o_max_next      = last_reg ? max_reg : '0;
                    o_max_cell_next = last_reg ? max_cell_reg : '0;
                    o_min_next      = last_reg ? min_reg : '0;
                    o_min_cell_next = last_reg ? min_cell_reg : '0;
                    o_avg_next      = last_reg ? avg_value : '0;
                    o_total_next    = last_reg ? total_reg : '0;
                    o_live_next     = last_reg ? live_reg : '0;
                    o_wrong_next    = last_reg && (live_reg != n_eff);
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    // State, statistics and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            max_reg       <= '0;
            max_cell_reg  <= '0;
            min_reg       <= cvpm_pkg::MIN_START;
            min_cell_reg  <= '0;
            total_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            max_reg       <= max_next;
            max_cell_reg  <= max_cell_next;
            min_reg       <= min_next;
            min_cell_reg  <= min_cell_next;
            total_reg     <= total_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the latched sample and the result.
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        code_reg       <= code_next;
        open_reg       <= open_next;
        over_res_reg   <= over_res_next;
        under_res_reg  <= under_res_next;
        last_reg       <= last_next;
        o_index_reg    <= o_index_next;
        o_over_reg     <= o_over_next;
        o_under_reg    <= o_under_next;
        o_done_reg     <= o_done_next;
        o_max_reg      <= o_max_next;
        o_max_cell_reg <= o_max_cell_next;
        o_min_reg      <= o_min_next;
        o_min_cell_reg <= o_min_cell_next;
        o_avg_reg      <= o_avg_next;
        o_total_reg    <= o_total_next;
        o_live_reg     <= o_live_next;
        o_wrong_reg    <= o_wrong_next;
    end

    assign out_valid     = out_valid_reg;
    assign sample_index  = o_index_reg;
    assign over_voltage  = o_over_reg;
    assign under_voltage = o_under_reg;
    assign scan_done     = o_done_reg;
    assign max_code      = o_max_reg;
    assign max_cell      = o_max_cell_reg;
    assign min_code      = o_min_reg;
    assign min_cell      = o_min_cell_reg;
    assign average_code  = o_avg_reg;
    assign total_code    = o_total_reg;
    assign live_count    = o_live_reg;
    assign count_wrong   = o_wrong_reg;

endmodule

@@ hw/rtl/cvpm_checker.sv @@
// ----------------------------------------------------------------------------
// cvpm_assertions: port-level checks of the cell voltage protection monitor
// Watches the result channel for handshake and statistics consistency and
// is attached to the top level by the bind statement below.
// ----------------------------------------------------------------------------
module cvpm_assertions (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [cvpm_pkg::CELL_W-1:0]  sample_index,
    input logic                         scan_done,
    input logic [cvpm_pkg::CODE_W-1:0]  max_code,
    input logic [cvpm_pkg::CODE_W-1:0]  min_code,
    input logic [cvpm_pkg::CODE_W-1:0]  average_code,
    input logic [cvpm_pkg::TOTAL_W-1:0] total_code,
    input logic [cvpm_pkg::COUNT_W-1:0] live_count,
    input logic                         count_wrong
);

    // A stalled result item stays offered with the same cell index.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_index))
    else $error("stalled result item changed or was dropped");

    // Statistics fields are zero on items that do not end a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !scan_done |-> max_code == '0 && total_code == '0 &&
                                    live_count == '0 && !count_wrong)
    else $error("statistics present on an item that does not end a scan");

    // With no live cell the average and total are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scan_done && live_count == '0 |-> average_code == '0 &&
                                                      total_code == '0)
    else $error("nonzero average or total without live cells");

    // Any live cell keeps the minimum at or below the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scan_done && live_count != '0 |-> min_code <= max_code)
    else $error("minimum above maximum in a scan with live cells");

endmodule

bind cell_voltage_protection_monitor cvpm_assertions u_cvpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_index (sample_index),
    .scan_done    (scan_done),
    .max_code     (max_code),
    .min_code     (min_code),
    .average_code (average_code),
    .total_code   (total_code),
    .live_count   (live_count),
    .count_wrong  (count_wrong)
);

@@ tb/cvpm_checker.sv @@
// ----------------------------------------------------------------------------
// cvpm_checker: result checker of the cell voltage protection monitor
// Watches the configuration port and both item channels, keeps its own copy
// of the per-cell fault timers and the scan statistics, predicts the result
// item of every accepted sample in range and compares it field by field
// with what the block delivers.
// ----------------------------------------------------------------------------
module cvpm_checker #(
    parameter int unsigned MAX_CELLS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cvpm_pkg::ADDR_W-1:0]  paddr,
    input  logic [cvpm_pkg::DATA_W-1:0]  pwdata,
    input  logic                         pready,
    // Input channel.
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         cmd,
    input  logic [cvpm_pkg::CELL_W-1:0]  cell_index,
    input  logic [cvpm_pkg::CODE_W-1:0]  cell_code,
    input  logic                         open_wire,
    // Output channel.
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [cvpm_pkg::CELL_W-1:0]  sample_index,
    input  logic                         over_voltage,
    input  logic                         under_voltage,
    input  logic                         scan_done,
    input  logic [cvpm_pkg::CODE_W-1:0]  max_code,
    input  logic [cvpm_pkg::CELL_W-1:0]  max_cell,
    input  logic [cvpm_pkg::CODE_W-1:0]  min_code,
    input  logic [cvpm_pkg::CELL_W-1:0]  min_cell,
    input  logic [cvpm_pkg::CODE_W-1:0]  average_code,
    input  logic [cvpm_pkg::TOTAL_W-1:0] total_code,
    input  logic [cvpm_pkg::COUNT_W-1:0] live_count,
    input  logic                         count_wrong,
    // Status toward the testbench top.
    output int                           mismatches,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Fault direction, used as the first index of the per-cell tables.
    localparam int OVER  = 0;
    localparam int UNDER = 1;

    typedef struct packed {
        logic [cvpm_pkg::CELL_W-1:0]  sample_index;
        logic                         over_voltage;
        logic                         under_voltage;
        logic                         scan_done;
        logic [cvpm_pkg::CODE_W-1:0]  max_code;
        logic [cvpm_pkg::CELL_W-1:0]  max_cell;
        logic [cvpm_pkg::CODE_W-1:0]  min_code;
        logic [cvpm_pkg::CELL_W-1:0]  min_cell;
        logic [cvpm_pkg::CODE_W-1:0]  average_code;
        logic [cvpm_pkg::TOTAL_W-1:0] total_code;
        logic [cvpm_pkg::COUNT_W-1:0] live_count;
        logic                         count_wrong;
    } cell_report_t;

    cvpm_pkg::cfg_t               active_cfg;
    logic [31:0]                  tick_count;
    logic [31:0]                  arm_time [2][MAX_CELLS];
    bit                           armed    [2][MAX_CELLS];
    bit                           tripped  [2][MAX_CELLS];
    logic [cvpm_pkg::CODE_W-1:0]  peak_code;
    logic [cvpm_pkg::CELL_W-1:0]  peak_cell;
    logic [cvpm_pkg::CODE_W-1:0]  floor_code;
    logic [cvpm_pkg::CELL_W-1:0]  floor_cell;
    logic [cvpm_pkg::TOTAL_W-1:0] code_sum;
    logic [cvpm_pkg::COUNT_W-1:0] live_cells;
    cell_report_t                 expected_reports [$];
    int                           fail_count = 0;

    assign mismatches = fail_count;

    // A cell count of zero acts as one, anything above the table as the table.
    function automatic int unsigned cells_active();
        int unsigned n;
        n = 32'(active_cfg.cells_in_use);
        if (n == 0)
            n = 1;
        if (n > MAX_CELLS)
            n = MAX_CELLS;
        return n;
    endfunction

    function automatic void clear_stats();
        peak_code  = '0;
        peak_cell  = '0;
        floor_code = cvpm_pkg::MIN_START;
        floor_cell = '0;
        code_sum   = '0;
        live_cells = '0;
    endfunction

    function automatic void reset_monitor();
        active_cfg = cvpm_pkg::CFG_RESET;
        tick_count = '0;
        for (int d = 0; d < 2; d++)
        begin
            for (int c = 0; c < MAX_CELLS; c++)
            begin
                arm_time[d][c] = '0;
                armed[d][c]    = 1'b0;
                tripped[d][c]  = 1'b0;
            end
        end
        clear_stats();
        expected_reports.delete();
    endfunction

    // Fault decision of one direction. In the soft band the condition has to
    // persist for more than the delay; an existing fault holds meanwhile.
    function automatic void judge_cell(int dir, int c, logic open, bit hard_hit,
                                       bit soft_hit,
                                       logic [cvpm_pkg::DELAY_W-1:0] delay);
        if (open)
            tripped[dir][c] = 1'b0;
        else if (hard_hit)
            tripped[dir][c] = 1'b1;
        else if (soft_hit)
        begin
            if (!armed[dir][c])
            begin
                armed[dir][c]    = 1'b1;
                arm_time[dir][c] = tick_count;
            end
            else if (tick_count - arm_time[dir][c] > 32'(delay))
            begin
                armed[dir][c]   = 1'b0;
                tripped[dir][c] = 1'b1;
            end
        end
        else
        begin
            armed[dir][c]   = 1'b0;
            tripped[dir][c] = 1'b0;
        end
    endfunction

    // Update of one cell sample; queues the result item it causes, if any.
    function automatic void predict_sample(logic [cvpm_pkg::CELL_W-1:0] idx,
                                           logic [cvpm_pkg::CODE_W-1:0] raw,
                                           logic open);
        int unsigned                  n;
        int                           c;
        logic [cvpm_pkg::CODE_W-1:0]  code;
        logic [cvpm_pkg::CODE_W:0]    biased;
        logic [cvpm_pkg::TOTAL_W:0]   sum;
        logic [cvpm_pkg::TOTAL_W-1:0] avg;
        cell_report_t                 r;
        n    = cells_active();
        c    = int'(idx);
        code = raw;
        if (32'(idx) >= n)
            return;
        // Cell zero opens a new scan and carries the calibration offset.
        if (idx == '0)
        begin
            clear_stats();
            biased = {1'b0, raw} + (cvpm_pkg::CODE_W + 1)'(active_cfg.first_cell_offset);
            code   = biased[cvpm_pkg::CODE_W] ? cvpm_pkg::CODE_MAX
                                              : biased[cvpm_pkg::CODE_W-1:0];
        end
        judge_cell(OVER, c, open, code >= active_cfg.hard_over_limit,
                   code >= active_cfg.soft_over_limit, active_cfg.over_delay_ticks);
        judge_cell(UNDER, c, open, code <= active_cfg.hard_under_limit,
                   code <= active_cfg.soft_under_limit, active_cfg.under_delay_ticks);
        // Open cells stay out of the statistics.
        if (!open)
        begin
            if (code > peak_code)
            begin
                peak_code = code;
                peak_cell = idx;
            end
            if (code < floor_code)
            begin
                floor_code = code;
                floor_cell = idx;
            end
            sum      = {1'b0, code_sum} + (cvpm_pkg::TOTAL_W + 1)'(code);
            code_sum = sum[cvpm_pkg::TOTAL_W] ? cvpm_pkg::TOTAL_MAX
                                              : sum[cvpm_pkg::TOTAL_W-1:0];
            if (live_cells != cvpm_pkg::LIVE_MAX)
                live_cells = live_cells + 1'b1;
        end
        r               = '0;
        r.sample_index  = idx;
        r.over_voltage  = tripped[OVER][c];
        r.under_voltage = tripped[UNDER][c];
        if (32'(idx) == n - 1)
        begin
            avg = (live_cells != '0) ? code_sum / (cvpm_pkg::TOTAL_W)'(live_cells) : '0;
            r.scan_done    = 1'b1;
            r.max_code     = peak_code;
            r.max_cell     = peak_cell;
            r.min_code     = floor_code;
            r.min_cell     = floor_cell;
            r.average_code = (avg > (cvpm_pkg::TOTAL_W)'(cvpm_pkg::CODE_MAX))
                             ? cvpm_pkg::CODE_MAX : avg[cvpm_pkg::CODE_W-1:0];
            r.total_code   = code_sum;
            r.live_count   = live_cells;
            r.count_wrong  = (32'(live_cells) != n);
        end
        expected_reports.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v,
                                        logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    function automatic void compare_report(cell_report_t want, cell_report_t got);
        check_field("sample_index", 32'(want.sample_index), 32'(got.sample_index));
        check_field("over_voltage", 32'(want.over_voltage), 32'(got.over_voltage));
        check_field("under_voltage", 32'(want.under_voltage), 32'(got.under_voltage));
        check_field("scan_done", 32'(want.scan_done), 32'(got.scan_done));
        check_field("max_code", 32'(want.max_code), 32'(got.max_code));
        check_field("max_cell", 32'(want.max_cell), 32'(got.max_cell));
        check_field("min_code", 32'(want.min_code), 32'(got.min_code));
        check_field("min_cell", 32'(want.min_cell), 32'(got.min_cell));
        check_field("average_code", 32'(want.average_code), 32'(got.average_code));
        check_field("total_code", 32'(want.total_code), 32'(got.total_code));
        check_field("live_count", 32'(want.live_count), 32'(got.live_count));
        check_field("count_wrong", 32'(want.count_wrong), 32'(got.count_wrong));
    endfunction

    // Everything is sampled at the rising edge, before the block updates.
    always @(posedge clk or negedge rst_n)
    begin : watch
        cell_report_t want;
        cell_report_t got;
        if (!rst_n)
        begin
            reset_monitor();
            outstanding <= 0;
        end
        else
        begin
            // Register writes.
            if (psel && penable && pwrite && pready)
            begin
                case (cvpm_pkg::reg_idx_t'(paddr[4:2]))
                    cvpm_pkg::REG_HARD_OVER:
                        active_cfg.hard_over_limit = pwdata[cvpm_pkg::CODE_W-1:0];
                    cvpm_pkg::REG_SOFT_OVER:
                        active_cfg.soft_over_limit = pwdata[cvpm_pkg::CODE_W-1:0];
                    cvpm_pkg::REG_HARD_UNDER:
                        active_cfg.hard_under_limit = pwdata[cvpm_pkg::CODE_W-1:0];
                    cvpm_pkg::REG_SOFT_UNDER:
                        active_cfg.soft_under_limit = pwdata[cvpm_pkg::CODE_W-1:0];
                    cvpm_pkg::REG_OVER_DELAY:
                        active_cfg.over_delay_ticks = pwdata[cvpm_pkg::DELAY_W-1:0];
                    cvpm_pkg::REG_UNDER_DELAY:
                        active_cfg.under_delay_ticks = pwdata[cvpm_pkg::DELAY_W-1:0];
                    cvpm_pkg::REG_CELLS:
                        active_cfg.cells_in_use = pwdata[cvpm_pkg::COUNT_W-1:0];
                    cvpm_pkg::REG_OFFSET:
                        active_cfg.first_cell_offset = pwdata[cvpm_pkg::OFFSET_W-1:0];
                    default: ;
                endcase
            end

            // Result items against the oldest expectation.
            if (out_valid && !out_stall)
            begin
                got = {sample_index, over_voltage, under_voltage, scan_done,
                       max_code, max_cell, min_code, min_cell, average_code,
                       total_code, live_count, count_wrong};
                if (expected_reports.size() == 0)
                begin
                    $error("result item for cell %0d with no item waiting", sample_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_report(want, got);
                end
            end

            // Input items.
            if (in_valid && !in_stall)
            begin
                if (cmd == cvpm_pkg::CMD_TICK)
                    tick_count = tick_count + 32'd1;
                else
                    predict_sample(cell_index, cell_code, open_wire);
            end

            outstanding <= expected_reports.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the cell voltage protection monitor
// Runs a short directed sequence over the limits, the fault delays, open
// cells and ignored samples, then several phases of random scans under
// different register settings, with random idling on both channels and one
// long output hold-off. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CELL_SLOTS    = 12;
    localparam int          IDLE_PCT      = 21;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_AT       = 150;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          QUIET_FROM    = 300;
    localparam int          QUIET_TO      = 420;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 100;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [cvpm_pkg::ADDR_W-1:0]  paddr;
    logic [cvpm_pkg::DATA_W-1:0]  pwdata;
    logic [cvpm_pkg::DATA_W-1:0]  prdata;
    logic                         pready;
    logic                         in_valid;
    logic                         in_stall;
    logic                         cmd;
    logic [cvpm_pkg::CELL_W-1:0]  cell_index;
    logic [cvpm_pkg::CODE_W-1:0]  cell_code;
    logic                         open_wire;
    logic                         out_valid;
    logic                         out_stall;
    logic [cvpm_pkg::CELL_W-1:0]  sample_index;
    logic                         over_voltage;
    logic                         under_voltage;
    logic                         scan_done;
    logic [cvpm_pkg::CODE_W-1:0]  max_code;
    logic [cvpm_pkg::CELL_W-1:0]  max_cell;
    logic [cvpm_pkg::CODE_W-1:0]  min_code;
    logic [cvpm_pkg::CELL_W-1:0]  min_cell;
    logic [cvpm_pkg::CODE_W-1:0]  average_code;
    logic [cvpm_pkg::TOTAL_W-1:0] total_code;
    logic [cvpm_pkg::COUNT_W-1:0] live_count;
    logic                         count_wrong;
    int                           mismatches;
    int                           outstanding;

    // Stimulus-side view of the settings and of the cell history.
    cvpm_pkg::cfg_t               cur_cfg;
    int unsigned                  eff_cells;
    logic [cvpm_pkg::CODE_W-1:0]  last_code [CELL_SLOTS];
    bit                           sender_quiet;
    int unsigned                  counted;

    cell_voltage_protection_monitor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .cell_index    (cell_index),
        .cell_code     (cell_code),
        .open_wire     (open_wire),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_index  (sample_index),
        .over_voltage  (over_voltage),
        .under_voltage (under_voltage),
        .scan_done     (scan_done),
        .max_code      (max_code),
        .max_cell      (max_cell),
        .min_code      (min_code),
        .min_cell      (min_cell),
        .average_code  (average_code),
        .total_code    (total_code),
        .live_count    (live_count),
        .count_wrong   (count_wrong)
    );

    cvpm_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .cell_index    (cell_index),
        .cell_code     (cell_code),
        .open_wire     (open_wire),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_index  (sample_index),
        .over_voltage  (over_voltage),
        .under_voltage (under_voltage),
        .scan_done     (scan_done),
        .max_code      (max_code),
        .max_cell      (max_cell),
        .min_code      (min_code),
        .min_cell      (min_cell),
        .average_code  (average_code),
        .total_code    (total_code),
        .live_count    (live_count),
        .count_wrong   (count_wrong),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // One register write: setup phase, then access phase. The port is left in
    // its access phase so that the next write can follow directly.
    task automatic apb_write(input cvpm_pkg::reg_idx_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic load_cfg(input cvpm_pkg::cfg_t c);
        apb_write(cvpm_pkg::REG_HARD_OVER, 32'(c.hard_over_limit));
        apb_write(cvpm_pkg::REG_SOFT_OVER, 32'(c.soft_over_limit));
        apb_write(cvpm_pkg::REG_HARD_UNDER, 32'(c.hard_under_limit));
        apb_write(cvpm_pkg::REG_SOFT_UNDER, 32'(c.soft_under_limit));
        apb_write(cvpm_pkg::REG_OVER_DELAY, 32'(c.over_delay_ticks));
        apb_write(cvpm_pkg::REG_UNDER_DELAY, 32'(c.under_delay_ticks));
        apb_write(cvpm_pkg::REG_CELLS, 32'(c.cells_in_use));
        apb_write(cvpm_pkg::REG_OFFSET, 32'(c.first_cell_offset));
        psel      <= 1'b0;
        penable   <= 1'b0;
        cur_cfg   = c;
        eff_cells = (c.cells_in_use == '0) ? 1 :
                    (32'(c.cells_in_use) > CELL_SLOTS) ? CELL_SLOTS : 32'(c.cells_in_use);
    endtask

    // Offers one item, after a random gap, and returns at its accepting edge.
    task automatic send_item(input logic c, input logic [cvpm_pkg::CELL_W-1:0] i,
                             input logic [cvpm_pkg::CODE_W-1:0] d, input logic ow);
        int gap;
        gap = 0;
        while (!sender_quiet && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        cell_index <= i;
        cell_code  <= d;
        open_wire  <= ow;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == cvpm_pkg::CMD_TICK || 32'(i) < eff_cells)
            counted++;
    endtask

    // Ticks carry random, unused payload bits.
    task automatic send_ticks(input int k);
        repeat (k)
            send_item(cvpm_pkg::CMD_TICK, 4'($urandom_range(15)),
                      16'($urandom_range(65535)), 1'($urandom_range(1)));
    endtask

    // Waits until every result has come, then for the block to go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [cvpm_pkg::CODE_W-1:0] near(
        input logic [cvpm_pkg::CODE_W-1:0] lim);
        int v;
        v = int'(lim);
        v = v + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[cvpm_pkg::CODE_W-1:0];
    endfunction

    // Codes cluster around the limits so that every band is hit.
    function automatic logic [cvpm_pkg::CODE_W-1:0] pick_code();
        case ($urandom_range(6))
            0: return near(cur_cfg.hard_over_limit);
            1: return near(cur_cfg.soft_over_limit);
            2: return near(cur_cfg.hard_under_limit);
            3: return near(cur_cfg.soft_under_limit);
            4: return 16'($urandom_range(65535));
            5: return ($urandom_range(1) != 0) ? cvpm_pkg::CODE_MAX : '0;
            default:
            begin
                if (32'(cur_cfg.soft_over_limit) > 32'(cur_cfg.soft_under_limit) + 2)
                    return 16'($urandom_range(32'(cur_cfg.soft_over_limit) - 1,
                                              32'(cur_cfg.soft_under_limit) + 1));
                return 16'($urandom_range(65535));
            end
        endcase
    endfunction

    function automatic cvpm_pkg::cfg_t rand_cfg();
        cvpm_pkg::cfg_t c;
        c.hard_over_limit   = 16'($urandom_range(50000, 40000));
        c.soft_over_limit   = c.hard_over_limit - 16'($urandom_range(3000));
        c.hard_under_limit  = 16'($urandom_range(28000, 20000));
        c.soft_under_limit  = c.hard_under_limit + 16'($urandom_range(5000));
        c.over_delay_ticks  = 16'($urandom_range(6));
        c.under_delay_ticks = 16'($urandom_range(6));
        c.cells_in_use      = 4'($urandom_range(12, 1));
        c.first_cell_offset = 10'($urandom_range(1023));
        return c;
    endfunction

    // A scan in cell order with ticks in between; cells tend to keep their
    // voltage so that soft-band conditions can persist. Some scans are cut.
    task automatic run_scan();
        int first;
        int last;
        logic [cvpm_pkg::CODE_W-1:0] code;
        first = ($urandom_range(99) < 90) ? 0 : int'($urandom_range(eff_cells - 1));
        last  = ($urandom_range(99) < 90) ? int'(eff_cells) - 1 :
                int'($urandom_range(eff_cells - 1, first));
        for (int i = first; i <= last; i++)
        begin
            if ($urandom_range(99) < 35)
                send_ticks(int'($urandom_range(3, 1)));
            code = ($urandom_range(99) < 60) ? near(last_code[i]) : pick_code();
            last_code[i] = code;
            send_item(cvpm_pkg::CMD_SAMPLE, i[cvpm_pkg::CELL_W-1:0], code,
                      $urandom_range(99) < 8);
        end
    endtask

    // Output side: random stalls, one long hold-off and one quiet stretch.
    initial
    begin : receiver
        int taken;
        bit held;
        taken     = 0;
        held      = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                taken++;
            if (!held && taken >= HOLD_AT)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (taken >= QUIET_FROM && taken < QUIET_TO)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        cvpm_pkg::cfg_t c;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        cmd          = cvpm_pkg::CMD_SAMPLE;
        cell_index   = '0;
        cell_code    = '0;
        open_wire    = 1'b0;
        sender_quiet = 1'b0;
        counted      = 0;
        cur_cfg      = cvpm_pkg::CFG_RESET;
        eff_cells    = CELL_SLOTS;
        foreach (last_code[i])
            last_code[i] = 16'd36000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: offset lifts cell zero onto the hard over limit,
        // the last cell enters the soft under band.
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd0, 16'd42070, 1'b0);
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd11, 16'd30000, 1'b0);
        send_ticks(1);
        settle();

        // Three cells, short delays, largest offset.
        c = '{16'd42500, 16'd42000, 16'd25000, 16'd30000, 16'd2, 16'd1, 4'd3, 10'd1023};
        load_cfg(c);
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd0, cvpm_pkg::CODE_MAX, 1'b0); // offset saturates
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd1, 16'd0, 1'b0);          // hard under
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd2, 16'd42100, 1'b0);      // soft over starts timing
        send_ticks(3);
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd2, 16'd42100, 1'b0);      // delay exceeded
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd2, 16'd42200, 1'b0);      // fault held in soft band
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd1, 16'd28000, 1'b0);      // soft under starts timing
        send_ticks(2);
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd1, 16'd28000, 1'b0);
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd1, 16'd0, 1'b1);          // open wire clears flags
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd2, cvpm_pkg::CODE_MAX, 1'b0); // scan without cell 0
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd5, 16'd1234, 1'b0);       // out of range
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd15, cvpm_pkg::CODE_MAX, 1'b1); // out of range
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd0, 16'd0, 1'b1);          // scan with no live cell
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd1, 16'd0, 1'b1);
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd2, 16'd0, 1'b1);
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd0, 16'd0, 1'b0);
        send_item(cvpm_pkg::CMD_SAMPLE, 4'd2, 16'd41000, 1'b0);

        // Random phases, each under its own settings.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    c = rand_cfg();
                    c.cells_in_use = 4'd12;
                end
                1: c = '{cvpm_pkg::CODE_MAX, 16'd0, 16'd0, cvpm_pkg::CODE_MAX, 16'd0, 16'd0,
                         4'd1, 10'd0};
                2: c = '{16'd0, cvpm_pkg::CODE_MAX, cvpm_pkg::CODE_MAX, 16'd0,
                         cvpm_pkg::CODE_MAX, cvpm_pkg::CODE_MAX, 4'd15, 10'd1023};
                3:
                begin
                    c = rand_cfg();
                    c.cells_in_use = 4'd0;
                end
                default: c = rand_cfg();
            endcase
            load_cfg(c);
            sender_quiet = (p == 4);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 85)
                    run_scan();
                else
                    send_item(1'($urandom_range(1)), 4'($urandom_range(15)),
                              16'($urandom_range(65535)), 1'($urandom_range(1)));
            end
        end
        sender_quiet = 1'b0;
        settle();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
